FILE: design/ilid_pkg.sv
package ilid_pkg;

    // fixed field widths
    localparam int ACTION_W   = 3;
    localparam int POS_W      = 8;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int LIST_LEN_W = 7;

    // default store depth
    localparam int CAPACITY_DEF = 64;

    // request actions
    localparam logic [ACTION_W-1:0] ACT_GET    = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_HEAD   = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_TAIL   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_INDEX  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_DELETE = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // store engine operations
    localparam logic [1:0] OP_GET    = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    // value returned when nothing is read
    localparam logic signed [VALUE_W-1:0] NOT_FOUND_VALUE = -32'sd1;

    // command from the request control to the store engine
    typedef struct packed {
        logic                      start;
        logic [1:0]                op;
        logic [POS_W-1:0]          pos;
        logic [POS_W-1:0]          len;
        logic signed [VALUE_W-1:0] value;
    } ilid_cmd_t;

    // response from the store engine
    typedef struct packed {
        logic                      done;
        logic signed [VALUE_W-1:0] rdata;
    } ilid_resp_t;

endpackage

FILE: design/ilid_store.sv
module ilid_store
    import ilid_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  ilid_cmd_t  cmd,
    output ilid_resp_t resp
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    localparam logic [1:0] E_IDLE  = 2'd0;
    localparam logic [1:0] E_GET   = 2'd1;
    localparam logic [1:0] E_SHIFT = 2'd2;
    localparam logic [1:0] E_FINAL = 2'd3;

    // entry store, one write and one read port
    logic signed [VALUE_W-1:0] mem [CAPACITY];
    logic signed [VALUE_W-1:0] rdata_reg;

    logic [1:0]                state_reg, state_next;
    logic [1:0]                op_reg, op_next;
    logic [AW-1:0]             pos_reg, pos_next;
    logic signed [VALUE_W-1:0] value_reg, value_next;
    logic [AW-1:0]             rd_addr_reg, rd_addr_next;
    logic [POS_W-1:0]          remaining_reg, remaining_next;
    logic                      pend_reg, pend_next;
    logic [AW-1:0]             pend_addr_reg, pend_addr_next;

    logic                      rd_en;
    logic [AW-1:0]             rd_addr;
    logic                      wr_en;
    logic [AW-1:0]             wr_addr;
    logic signed [VALUE_W-1:0] wr_data;
    logic                      done;

    // sequencer: one read and one write per cycle while shifting
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        pos_next       = pos_reg;
        value_next     = value_reg;
        rd_addr_next   = rd_addr_reg;
        remaining_next = remaining_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        rd_en          = 1'b0;
        rd_addr        = rd_addr_reg;
        wr_en          = 1'b0;
        wr_addr        = pend_addr_reg;
        wr_data        = rdata_reg;
        done           = 1'b0;
        unique case (state_reg)
            E_IDLE:
            begin
                if (cmd.start)
                begin
                    op_next    = cmd.op;
                    pos_next   = AW'(cmd.pos);
                    value_next = cmd.value;
                    pend_next  = 1'b0;
                    if (cmd.op == OP_GET)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = AW'(cmd.pos);
                        state_next = E_GET;
                    end
                    else if (cmd.op == OP_INSERT)
                    begin
                        // move entries len-1 down to pos up by one
                        rd_addr_next   = AW'(cmd.len - 8'd1);
                        remaining_next = cmd.len - cmd.pos;
                        state_next     = E_SHIFT;
                    end
                    else
                    begin
                        // move entries pos+1 up to len-1 down by one
                        rd_addr_next   = AW'(cmd.pos + 8'd1);
                        remaining_next = cmd.len - cmd.pos - 8'd1;
                        state_next     = E_SHIFT;
                    end
                end
            end
            E_GET:
            begin
                done       = 1'b1;
                state_next = E_IDLE;
            end
            E_SHIFT:
            begin
                // write back the entry read last cycle
                wr_en   = pend_reg;
                wr_addr = pend_addr_reg;
                wr_data = rdata_reg;
                // fetch the next entry
                rd_en     = (remaining_reg != '0);
                rd_addr   = rd_addr_reg;
                pend_next = (remaining_reg != '0);
                if (op_reg == OP_INSERT)
                begin
                    pend_addr_next = rd_addr_reg + AW'(1);
                    rd_addr_next   = rd_addr_reg - AW'(1);
                end
                else
                begin
                    pend_addr_next = rd_addr_reg - AW'(1);
                    rd_addr_next   = rd_addr_reg + AW'(1);
                end
                if (remaining_reg != '0)
                begin
                    remaining_next = remaining_reg - 8'd1;
                end
                else
                begin
                    state_next = E_FINAL;
                end
            end
            E_FINAL:
            begin
                // insert drops the new value into the gap
                wr_en      = (op_reg == OP_INSERT);
                wr_addr    = pos_reg;
                wr_data    = value_reg;
                done       = 1'b1;
                state_next = E_IDLE;
            end
            default:
            begin
                state_next = E_IDLE;
            end
        endcase
    end

    // memory ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= E_IDLE;
            remaining_reg <= '0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            remaining_reg <= remaining_next;
            pend_reg      <= pend_next;
        end
    end

    // operand registers
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        pos_reg       <= pos_next;
        value_reg     <= value_next;
        rd_addr_reg   <= rd_addr_next;
        pend_addr_reg <= pend_addr_next;
    end

    assign resp = '{done: done, rdata: rdata_reg};

endmodule

FILE: design/indexed_list_insert_delete.sv
// get: the store engine reads the entry, then the result goes to the output register
// insert and delete: the store engine moves the entries between position and the end by one;
// one request at a time, so the input is held off until the result is in the output register
// a rejected request answers without the store engine; a stalled result holds the next
// result, and so the input, off until it leaves; the shift engine moves one entry per cycle
// reset clears the length count and the handshake state; entries need no clearing pass
module indexed_list_insert_delete
    import ilid_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [ACTION_W-1:0]          action,
    input  logic [POS_W-1:0]             position,
    input  logic signed [VALUE_W-1:0]    value,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [VALUE_W-1:0]    read_value,
    output logic                         found,
    output logic [STATUS_W-1:0]          status,
    output logic [LIST_LEN_W-1:0]        list_length
);

    localparam int LW = $clog2(CAPACITY + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_RESP = 2'd2;

    logic [1:0]                state_reg, state_next;
    logic [LW-1:0]             length_reg, length_next;
    logic [1:0]                op_reg, op_next;
    logic signed [VALUE_W-1:0] res_value_reg, res_value_next;
    logic                      res_found_reg, res_found_next;
    logic [STATUS_W-1:0]       res_status_reg, res_status_next;

    logic                      out_valid_reg, out_valid_next;
    logic signed [VALUE_W-1:0] read_value_reg, read_value_next;
    logic                      found_reg, found_next;
    logic [STATUS_W-1:0]       status_reg, status_next;
    logic [LIST_LEN_W-1:0]     list_length_reg, list_length_next;

    ilid_cmd_t                 cmd;
    ilid_resp_t                resp;

    logic                      accept;
    logic [POS_W-1:0]          len8;
    logic [POS_W-1:0]          add_pos;
    logic                      out_free;

    assign accept   = in_valid && !in_stall;
    assign len8     = POS_W'(length_reg);
    assign out_free = !out_valid_reg || !out_stall;

    // insert position per add action
    always_comb
    begin
        unique case (action)
            ACT_HEAD: add_pos = '0;
            ACT_TAIL: add_pos = len8;
            default:  add_pos = position;
        endcase
    end

    // request decode and sequencing
    always_comb
    begin
        state_next      = state_reg;
        length_next     = length_reg;
        op_next         = op_reg;
        res_value_next  = res_value_reg;
        res_found_next  = res_found_reg;
        res_status_next = res_status_reg;
        cmd.start       = 1'b0;
        cmd.op          = OP_GET;
        cmd.pos         = position;
        cmd.len         = len8;
        cmd.value       = value;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_value_next  = NOT_FOUND_VALUE;
                    res_found_next  = 1'b0;
                    res_status_next = ST_RANGE;
                    state_next      = S_RESP;
                    unique case (action)
                        ACT_GET:
                        begin
                            if (position < len8)
                            begin
                                cmd.start  = 1'b1;
                                cmd.op     = OP_GET;
                                state_next = S_RUN;
                            end
                        end
                        ACT_HEAD, ACT_TAIL, ACT_INDEX:
                        begin
                            if (add_pos > len8)
                            begin
                                res_status_next = ST_RANGE;
                            end
                            else if (length_reg == LW'(CAPACITY))
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                cmd.start  = 1'b1;
                                cmd.op     = OP_INSERT;
                                cmd.pos    = add_pos;
                                state_next = S_RUN;
                            end
                        end
                        ACT_DELETE:
                        begin
                            if (position < len8)
                            begin
                                cmd.start  = 1'b1;
                                cmd.op     = OP_DELETE;
                                state_next = S_RUN;
                            end
                        end
                        default:
                        begin
                            res_status_next = ST_RANGE;
                        end
                    endcase
                    op_next = cmd.op;
                end
            end
            S_RUN:
            begin
                if (resp.done)
                begin
                    res_status_next = ST_DONE;
                    state_next      = S_RESP;
                    if (op_reg == OP_GET)
                    begin
                        res_value_next = resp.rdata;
                        res_found_next = 1'b1;
                    end
                    else if (op_reg == OP_INSERT)
                    begin
                        length_next = length_reg + LW'(1);
                    end
                    else
                    begin
                        length_next = length_reg - LW'(1);
                    end
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register, loaded when the result slot is free
    always_comb
    begin
        out_valid_next   = out_valid_reg;
        read_value_next  = read_value_reg;
        found_next       = found_reg;
        status_next      = status_reg;
        list_length_next = list_length_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (state_reg == S_RESP && out_free)
        begin
            out_valid_next   = 1'b1;
            read_value_next  = res_value_reg;
            found_next       = res_found_reg;
            status_next      = res_status_reg;
            list_length_next = LIST_LEN_W'(length_reg);
        end
    end

    ilid_store #(
        .CAPACITY (CAPACITY)
    ) u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .resp  (resp)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            length_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            length_reg    <= length_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload registers
    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        res_value_reg   <= res_value_next;
        res_found_reg   <= res_found_next;
        res_status_reg  <= res_status_next;
        read_value_reg  <= read_value_next;
        found_reg       <= found_next;
        status_reg      <= status_next;
        list_length_reg <= list_length_next;
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign read_value  = read_value_reg;
    assign found       = found_reg;
    assign status      = status_reg;
    assign list_length = list_length_reg;

    // length never passes the store depth
    assert property (@(posedge clk) disable iff (!rst_n)
        length_reg <= LW'(CAPACITY))
        else $error("list length above capacity");

    // an accepted transaction blocks the input until its result is built
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> in_stall)
        else $error("input taken while a request is in progress");

    // the store engine only finishes while a request waits on it
    assert property (@(posedge clk) disable iff (!rst_n)
        resp.done |-> state_reg == S_RUN)
        else $error("store engine done outside a running request");

    // a hit is always a clean get, a miss always reads as all ones
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> status == ST_DONE)
        else $error("found flagged with an error status");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> read_value == NOT_FOUND_VALUE)
        else $error("miss result carries a stored value");

endmodule
